@@ rtl/heatmap_colorize_blend_top_macros.svh @@
// Assertion macros used by the checker file of this block.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef HEATMAP_COLORIZE_BLEND_TOP_MACROS_SVH
`define HEATMAP_COLORIZE_BLEND_TOP_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define HCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heatmap blend implication check failed");

// Condition that must hold on every rising edge outside reset.
`define HCB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("heatmap blend invariant check failed");

`endif

@@ rtl/hcb_pkg.sv @@
`default_nettype none

package hcb_pkg;

  localparam int unsigned INT_W = 17;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned POS_W = 15;

  localparam logic [CH_W-1:0]  WEIGHT_RESET = 8'd155;
  localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;
  localparam logic [CH_W-1:0]  CH_MIN       = 8'd0;
  localparam logic [POS_W-1:0] QUARTER      = 15'd16384;

  // Quarter-range segments of the colour ramp.
  typedef enum logic [1:0] {
    SEG_BLUE_CYAN    = 2'd0,
    SEG_CYAN_GREEN   = 2'd1,
    SEG_GREEN_YELLOW = 2'd2,
    SEG_YELLOW_RED   = 2'd3
  } seg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  // Word handed from the ramp stage to the blend stage.
  typedef struct packed {
    logic valid;
    logic bypass;
    pix_t orig;
    pix_t ramp;
  } ramp_word_t;

  // floor(255 * pos / 16384), with 255 * pos formed as (pos << 8) - pos.
  function automatic logic [CH_W-1:0] ramp_up(input logic [POS_W-1:0] pos);
    logic [POS_W+CH_W-1:0] prod;
    prod = {pos, 8'd0} - {8'd0, pos};
    return prod[POS_W+CH_W-2:POS_W-1];
  endfunction

  function automatic logic [CH_W-1:0] ramp_down(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] rest;
    rest = QUARTER - pos;
    return ramp_up(rest);
  endfunction

  // floor((orig * w + ramp * (255 - w)) / 255). The sum never exceeds
  // 255 * 255, and for such values (x + (x >> 8) + 1) >> 8 is the exact quotient.
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] orig,
                                            input logic [CH_W-1:0] ramp,
                                            input logic [CH_W-1:0] w);
    logic [2*CH_W-1:0] sum;
    logic [2*CH_W-1:0] adj;
    sum = ({8'd0, orig} * {8'd0, w}) + ({8'd0, ramp} * {8'd0, ~w});
    adj = sum + {8'd0, sum[2*CH_W-1:CH_W]} + 16'd1;
    return adj[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/hcb_ramp.sv @@
`default_nettype none

module hcb_ramp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [hcb_pkg::INT_W-1:0] intensity,
  input  wire hcb_pkg::pix_t            pix,
  output hcb_pkg::ramp_word_t           word_r
);

  hcb_pkg::seg_t                seg;
  logic [hcb_pkg::POS_W-1:0]    pos;
  hcb_pkg::pix_t                ramp_nxt;
  logic                         valid_r;
  logic                         bypass_r;
  hcb_pkg::pix_t                orig_r;
  hcb_pkg::pix_t                ramp_r;

  // Anything at or above full scale lands on the last point of the top quarter.
  always_comb begin
    if (intensity[hcb_pkg::INT_W-1]) begin
      seg = hcb_pkg::SEG_YELLOW_RED;
      pos = hcb_pkg::QUARTER;
    end else begin
      seg = hcb_pkg::seg_t'(intensity[15:14]);
      pos = {1'b0, intensity[13:0]};
    end
  end

  always_comb begin
    case (seg)
      hcb_pkg::SEG_BLUE_CYAN: begin
        ramp_nxt.blue  = hcb_pkg::CH_MAX;
        ramp_nxt.green = hcb_pkg::ramp_up(pos);
        ramp_nxt.red   = hcb_pkg::CH_MIN;
      end
      hcb_pkg::SEG_CYAN_GREEN: begin
        ramp_nxt.blue  = hcb_pkg::ramp_down(pos);
        ramp_nxt.green = hcb_pkg::CH_MAX;
        ramp_nxt.red   = hcb_pkg::CH_MIN;
      end
      hcb_pkg::SEG_GREEN_YELLOW: begin
        ramp_nxt.blue  = hcb_pkg::CH_MIN;
        ramp_nxt.green = hcb_pkg::CH_MAX;
        ramp_nxt.red   = hcb_pkg::ramp_up(pos);
      end
      hcb_pkg::SEG_YELLOW_RED: begin
        ramp_nxt.blue  = hcb_pkg::CH_MIN;
        ramp_nxt.green = hcb_pkg::ramp_down(pos);
        ramp_nxt.red   = hcb_pkg::CH_MAX;
      end
      default: begin
        ramp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bypass_r <= (intensity == '0);
    orig_r   <= pix;
    ramp_r   <= ramp_nxt;
  end

  assign word_r.valid  = valid_r;
  assign word_r.bypass = bypass_r;
  assign word_r.orig   = orig_r;
  assign word_r.ramp   = ramp_r;

endmodule

`default_nettype wire

@@ rtl/hcb_blend.sv @@
`default_nettype none

module hcb_blend (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire hcb_pkg::ramp_word_t     word,
  input  wire logic [hcb_pkg::CH_W-1:0] weight,
  output logic                         valid_r,
  output hcb_pkg::pix_t                pix_r
);

  hcb_pkg::pix_t pix_nxt;

  // A zero intensity passes the background pixel through untouched.
  always_comb begin
    if (word.bypass) begin
      pix_nxt = word.orig;
    end else begin
      pix_nxt.blue  = hcb_pkg::blend(word.orig.blue,  word.ramp.blue,  weight);
      pix_nxt.green = hcb_pkg::blend(word.orig.green, word.ramp.green, weight);
      pix_nxt.red   = hcb_pkg::blend(word.orig.red,   word.ramp.red,   weight);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= word.valid;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/heatmap_colorize_blend_top.sv @@
// Heat map colouriser: every word carries one background pixel (blue, green,
// red) and a heat intensity in unsigned Q1.16, where 65536 stands for 1.0 and
// larger codes count as 1.0. The intensity picks a colour on a ramp from blue
// through cyan, green and yellow to red, and that colour is blended over the
// pixel with the background weight held in cfg_wr_data's register (reset 155,
// out of 255). A zero intensity returns the pixel unchanged. A word is taken
// at every rising edge with start high; busy is never raised, so one pixel can
// enter in every cycle. Each result is driven on the outputs, with out_valid
// high, for exactly one cycle, in the order the words came in. The receiver cannot
// stall the block: a result that is not captured in its cycle is gone. Each word
// passes three register stages: the input register, the ramp register and the
// result register. The background weight may only be changed while no pixel is
// in flight.

`default_nettype none

module heatmap_colorize_blend_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [hcb_pkg::INT_W-1:0] in_intensity,
  input  wire logic [hcb_pkg::CH_W-1:0]  in_blue,
  input  wire logic [hcb_pkg::CH_W-1:0]  in_green,
  input  wire logic [hcb_pkg::CH_W-1:0]  in_red,
  output logic                           out_valid,
  output logic [hcb_pkg::CH_W-1:0]       out_blue,
  output logic [hcb_pkg::CH_W-1:0]       out_green,
  output logic [hcb_pkg::CH_W-1:0]       out_red,
  input  wire logic                      cfg_wr_en,
  input  wire logic [hcb_pkg::CH_W-1:0]  cfg_wr_data
);

  // Background weight register.
  logic [hcb_pkg::CH_W-1:0]  weight_r;

  // Input register stage.
  logic                      in_valid_r;
  logic [hcb_pkg::INT_W-1:0] in_int_r;
  hcb_pkg::pix_t             in_pix_r;

  hcb_pkg::ramp_word_t       ramp_word;
  hcb_pkg::pix_t             out_pix;

  // The pipeline never stalls, so the block is always ready for a word.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= hcb_pkg::WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  // Payload is captured unconditionally; the valid bit says whether it counts.
  always_ff @(posedge clk) begin
    in_int_r       <= in_intensity;
    in_pix_r.blue  <= in_blue;
    in_pix_r.green <= in_green;
    in_pix_r.red   <= in_red;
  end

  // Second stage: choose the ramp segment and work out the ramp colour.
  hcb_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .intensity (in_int_r),
    .pix       (in_pix_r),
    .word_r    (ramp_word)
  );

  // Third stage: blend the ramp colour over the pixel into the result register.
  hcb_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .word    (ramp_word),
    .weight  (weight_r),
    .valid_r (out_valid),
    .pix_r   (out_pix)
  );

  assign out_blue  = out_pix.blue;
  assign out_green = out_pix.green;
  assign out_red   = out_pix.red;

endmodule

`default_nettype wire

@@ rtl/hcb_checker.sv @@
`default_nettype none

`include "heatmap_colorize_blend_top_macros.svh"

module hcb_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [hcb_pkg::INT_W-1:0] in_intensity,
  input wire logic [hcb_pkg::CH_W-1:0]  in_blue,
  input wire logic [hcb_pkg::CH_W-1:0]  in_green,
  input wire logic [hcb_pkg::CH_W-1:0]  in_red,
  input wire logic                      out_valid,
  input wire logic [hcb_pkg::CH_W-1:0]  out_blue,
  input wire logic [hcb_pkg::CH_W-1:0]  out_green,
  input wire logic [hcb_pkg::CH_W-1:0]  out_red
);

  // The pipeline has no stall path, so it must never refuse a word.
  `HCB_ASSERT_ALWAYS(a_never_busy, !busy)

  // Every word taken later yields a result with out_valid high.
  `HCB_ASSERT_IMPL(a_result_follows, start && !busy, ##3 out_valid)

  // No result appears without a word taken earlier that it belongs to.
  `HCB_ASSERT_IMPL(a_no_spurious, out_valid, $past(start && !busy && rst_n, 3))

  // A zero intensity returns the background pixel unchanged.
  `HCB_ASSERT_IMPL(a_zero_passthrough, start && !busy && (in_intensity == '0), ##3 ((out_blue == $past(in_blue, 3)) && (out_green == $past(in_green, 3)) && (out_red == $past(in_red, 3))))

endmodule

bind heatmap_colorize_blend_top hcb_checker u_hcb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_intensity (in_intensity),
  .in_blue      (in_blue),
  .in_green     (in_green),
  .in_red       (in_red),
  .out_valid    (out_valid),
  .out_blue     (out_blue),
  .out_green    (out_green),
  .out_red      (out_red)
);

`default_nettype wire
